FILE: rtl/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg: shared types and constants for the rational arithmetic unit
// Payload structs, command codes, controller states and datapath commands.
// ----------------------------------------------------------------------------
package rau_pkg;

	localparam int OPERAND_WIDTH = 32;
	localparam int NW = OPERAND_WIDTH;      // numerator width
	localparam int DW = OPERAND_WIDTH - 1;  // denominator width
	localparam int WW = 64;                 // internal work width
	localparam int CW = 7;                  // bit counter width (0..64)

	localparam logic [2:0] CMD_ADD = 3'd0;
	localparam logic [2:0] CMD_SUB = 3'd1;
	localparam logic [2:0] CMD_MUL = 3'd2;
	localparam logic [2:0] CMD_DIV = 3'd3;
	localparam logic [2:0] CMD_RED = 3'd4;

	typedef struct packed {
		logic [2:0]          command;
		logic signed [31:0]  num_a;
		logic [30:0]         den_a;
		logic signed [31:0]  num_b;
		logic [30:0]         den_b;
	} rau_in_t;

	typedef struct packed {
		logic        negative;
		logic [62:0] whole_part;
		logic [61:0] frac_num;
		logic [62:0] frac_den;
		logic        infinite;
	} rau_out_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_GA_START, ST_GA_RUN, ST_DA_START, ST_DA_RUN, ST_DA2_START, ST_DA2_RUN,
		ST_GB_START, ST_GB_RUN, ST_DB_START, ST_DB_RUN, ST_DB2_START, ST_DB2_RUN,
		ST_MUL1, ST_MUL2, ST_MUL3, ST_COMB,
		ST_SPLIT_START, ST_SPLIT_RUN,
		ST_GF_START, ST_GF_RUN, ST_DF_START, ST_DF_RUN, ST_DF2_START, ST_DF2_RUN,
		ST_OUT
	} rau_state_t;

	// datapath operation requested by the controller
	typedef enum logic [4:0] {
		OP_NONE, OP_LOAD,
		OP_GA_INIT, OP_GB_INIT, OP_GF_INIT, OP_GCD_STEP,
		OP_DA_INIT, OP_DA2_INIT, OP_DB_INIT, OP_DB2_INIT,
		OP_SPLIT_INIT, OP_DF_INIT, OP_DF2_INIT, OP_DIV_STEP,
		OP_DA_DONE, OP_DA2_DONE, OP_DB_DONE, OP_DB2_DONE,
		OP_SPLIT_DONE, OP_DF_DONE, OP_DF2_DONE,
		OP_MUL1, OP_MUL2, OP_MUL3, OP_COMB
	} rau_op_t;

	typedef struct packed {
		rau_op_t op;
	} rau_cmd_t;

	typedef struct packed {
		logic gcd_done;   // remainder-step loop finished
		logic div_done;   // divider finished
		logic na_zero;    // reduced numerator a is zero
		logic nb_zero;    // reduced numerator b is zero
		logic n_zero;     // combined numerator is zero
		logic fn_zero;    // fractional remainder is zero
	} rau_stat_t;

endpackage

FILE: rtl/rau_ctrl.sv
// ----------------------------------------------------------------------------
// rau_ctrl: sequencing controller
// Steps operand reduction, combine, mixed split and final reduction.
// ----------------------------------------------------------------------------
module rau_ctrl import rau_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  rau_stat_t  stat,
	output rau_cmd_t   cmd
);

	rau_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:        if (in_valid) state_d = ST_GA_START;
			ST_GA_START:    state_d = stat.na_zero ? ST_GB_START : ST_GA_RUN;
			ST_GA_RUN:      if (stat.gcd_done) state_d = ST_DA_START;
			ST_DA_START:    state_d = ST_DA_RUN;
			ST_DA_RUN:      if (stat.div_done) state_d = ST_DA2_START;
			ST_DA2_START:   state_d = ST_DA2_RUN;
			ST_DA2_RUN:     if (stat.div_done) state_d = ST_GB_START;
			ST_GB_START:    state_d = stat.nb_zero ? ST_MUL1 : ST_GB_RUN;
			ST_GB_RUN:      if (stat.gcd_done) state_d = ST_DB_START;
			ST_DB_START:    state_d = ST_DB_RUN;
			ST_DB_RUN:      if (stat.div_done) state_d = ST_DB2_START;
			ST_DB2_START:   state_d = ST_DB2_RUN;
			ST_DB2_RUN:     if (stat.div_done) state_d = ST_MUL1;
			ST_MUL1:        state_d = ST_MUL2;
			ST_MUL2:        state_d = ST_MUL3;
			ST_MUL3:        state_d = ST_COMB;
			ST_COMB:        state_d = ST_SPLIT_START;
			ST_SPLIT_START: state_d = stat.n_zero ? ST_OUT : ST_SPLIT_RUN;
			ST_SPLIT_RUN:   if (stat.div_done) state_d = ST_GF_START;
			ST_GF_START:    state_d = stat.fn_zero ? ST_OUT : ST_GF_RUN;
			ST_GF_RUN:      if (stat.gcd_done) state_d = ST_DF_START;
			ST_DF_START:    state_d = ST_DF_RUN;
			ST_DF_RUN:      if (stat.div_done) state_d = ST_DF2_START;
			ST_DF2_START:   state_d = ST_DF2_RUN;
			ST_DF2_RUN:     if (stat.div_done) state_d = ST_OUT;
			ST_OUT:         if (out_ready) state_d = ST_IDLE;
			default:        state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		out_valid = 1'b0;
		cmd.op    = OP_NONE;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) cmd.op = OP_LOAD;
			end
			ST_GA_START:    cmd.op = OP_GA_INIT;
			ST_GB_START:    cmd.op = OP_GB_INIT;
			ST_GF_START:    cmd.op = OP_GF_INIT;
			ST_GA_RUN, ST_GB_RUN, ST_GF_RUN: cmd.op = OP_GCD_STEP;
			ST_DA_START:    cmd.op = OP_DA_INIT;
			ST_DA2_START:   cmd.op = OP_DA2_INIT;
			ST_DB_START:    cmd.op = OP_DB_INIT;
			ST_DB2_START:   cmd.op = OP_DB2_INIT;
			ST_SPLIT_START: cmd.op = OP_SPLIT_INIT;
			ST_DF_START:    cmd.op = OP_DF_INIT;
			ST_DF2_START:   cmd.op = OP_DF2_INIT;
			ST_DA_RUN:      cmd.op = stat.div_done ? OP_DA_DONE : OP_DIV_STEP;
			ST_DA2_RUN:     cmd.op = stat.div_done ? OP_DA2_DONE : OP_DIV_STEP;
			ST_DB_RUN:      cmd.op = stat.div_done ? OP_DB_DONE : OP_DIV_STEP;
			ST_DB2_RUN:     cmd.op = stat.div_done ? OP_DB2_DONE : OP_DIV_STEP;
			ST_SPLIT_RUN:   cmd.op = stat.div_done ? OP_SPLIT_DONE : OP_DIV_STEP;
			ST_DF_RUN:      cmd.op = stat.div_done ? OP_DF_DONE : OP_DIV_STEP;
			ST_DF2_RUN:     cmd.op = stat.div_done ? OP_DF2_DONE : OP_DIV_STEP;
			ST_MUL1:        cmd.op = OP_MUL1;
			ST_MUL2:        cmd.op = OP_MUL2;
			ST_MUL3:        cmd.op = OP_MUL3;
			ST_COMB:        cmd.op = OP_COMB;
			ST_OUT:         out_valid = 1'b1;
			default:        cmd.op = OP_NONE;
		endcase
	end

endmodule

FILE: rtl/rau_dp.sv
// ----------------------------------------------------------------------------
// rau_dp: arithmetic datapath
// Operand registers, one restoring divider that also runs the Euclid
// steps, and a 32x32 multiplier shared across the products.
// ----------------------------------------------------------------------------
module rau_dp import rau_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  rau_in_t   in_data,
	input  rau_cmd_t  cmd,
	output rau_stat_t stat,
	output rau_out_t  out_data
);

	logic [2:0]     op_q;
	logic           sa_q, sb_q, sign_q, inf_q;
	logic [WW-1:0]  na_q, da_q, nb_q, db_q;
	logic [WW-1:0]  p1_q, p2_q, p3_q;     // products
	logic [WW-1:0]  n_q, d_q;             // combined fraction
	logic [WW-1:0]  whole_q, fn_q, fd_q;
	// Euclid divisor; the dividend enters through the divider
	logic [WW-1:0]  gy_q;
	// shared divider: dividend shifts out, remainder builds up
	logic [WW-1:0]  dv_q, dr_q, rm_q, qt_q;
	logic [CW-1:0]  cnt_q;

	logic [WW-1:0]  dec_na, dec_nb;
	logic [31:0]    mul_a, mul_b;
	logic [WW-1:0]  mul_p;
	logic [WW:0]    rm_sh, rm_sub;
	logic           s2;

	// Euclid step through the divider: dv/dr hold the pair; when the
	// divider ends with a nonzero remainder, divisor and remainder move up.
	// A zero remainder leaves the gcd in gy.
	always_comb begin
		dec_na = WW'(in_data.num_a[NW-1] ? (~{{(WW-NW){1'b0}}, in_data.num_a} + 1'b1) &
			{{(WW-NW){1'b0}}, {NW{1'b1}}} | (in_data.num_a == {1'b1, {(NW-1){1'b0}}} ?
			(WW'(1) << (NW-1)) : '0) : {{(WW-NW){1'b0}}, in_data.num_a});
		dec_nb = WW'(in_data.num_b[NW-1] ? (~{{(WW-NW){1'b0}}, in_data.num_b} + 1'b1) &
			{{(WW-NW){1'b0}}, {NW{1'b1}}} | (in_data.num_b == {1'b1, {(NW-1){1'b0}}} ?
			(WW'(1) << (NW-1)) : '0) : {{(WW-NW){1'b0}}, in_data.num_b});
	end

	assign s2 = (op_q == CMD_SUB) ? ~sb_q : sb_q;

	// MUL1: na*db (na*nb for multiply), MUL2: nb*da, MUL3: da*db
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_MUL1: begin
				mul_a = na_q[31:0];
				mul_b = (op_q == CMD_MUL) ? nb_q[31:0] : db_q[31:0];
			end
			OP_MUL2: begin mul_a = nb_q[31:0]; mul_b = da_q[31:0]; end
			OP_MUL3: begin mul_a = da_q[31:0]; mul_b = db_q[31:0]; end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
		mul_p = WW'(mul_a) * WW'(mul_b);
	end

	assign rm_sh  = {rm_q, dv_q[WW-1]};
	assign rm_sub = rm_sh - {1'b0, dr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			case (cmd.op)
				OP_DA_INIT, OP_DA2_INIT, OP_DB_INIT, OP_DB2_INIT, OP_SPLIT_INIT,
				OP_DF_INIT, OP_DF2_INIT: cnt_q <= CW'(WW);
				OP_GA_INIT, OP_GB_INIT, OP_GF_INIT: cnt_q <= CW'(WW);
				OP_DIV_STEP, OP_GCD_STEP: if (cnt_q != '0) cnt_q <= cnt_q - 1'b1;
				                          else if (cmd.op == OP_GCD_STEP && rm_q != '0)
				                          	cnt_q <= CW'(WW);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				op_q <= in_data.command;
				sa_q <= in_data.num_a[NW-1];
				sb_q <= in_data.num_b[NW-1];
				na_q <= dec_na;
				nb_q <= dec_nb;
				da_q <= (in_data.den_a[DW-1:0] == '0) ? WW'(1) : WW'(in_data.den_a[DW-1:0]);
				db_q <= (in_data.den_b[DW-1:0] == '0) ? WW'(1) : WW'(in_data.den_b[DW-1:0]);
				inf_q <= 1'b0;
			end
			OP_GA_INIT: begin
				if (na_q == '0) da_q <= WW'(1);
				gy_q <= da_q;
				dv_q <= na_q; dr_q <= da_q; rm_q <= '0; qt_q <= '0;
			end
			OP_GB_INIT: begin
				if (nb_q == '0) db_q <= WW'(1);
				gy_q <= db_q;
				dv_q <= nb_q; dr_q <= db_q; rm_q <= '0; qt_q <= '0;
			end
			OP_GF_INIT: begin
				gy_q <= d_q;
				dv_q <= fn_q; dr_q <= d_q; rm_q <= '0; qt_q <= '0;
			end
			OP_GCD_STEP, OP_DIV_STEP: begin
				if (cnt_q != '0) begin
					dv_q <= {dv_q[WW-2:0], 1'b0};
					if (!rm_sub[WW]) begin
						rm_q <= rm_sub[WW-1:0];
						qt_q <= {qt_q[WW-2:0], 1'b1};
					end else begin
						rm_q <= rm_sh[WW-1:0];
						qt_q <= {qt_q[WW-2:0], 1'b0};
					end
				end else if (cmd.op == OP_GCD_STEP && rm_q != '0) begin
					// x mod y done: shift pair, start next remainder
					gy_q <= rm_q;
					dv_q <= gy_q; dr_q <= rm_q; rm_q <= '0; qt_q <= '0;
				end
			end
			OP_DA_INIT:    begin dv_q <= na_q; dr_q <= gy_q; rm_q <= '0; qt_q <= '0; end
			OP_DA_DONE:    na_q <= qt_q;
			OP_DA2_INIT:   begin dv_q <= da_q; dr_q <= gy_q; rm_q <= '0; qt_q <= '0; end
			OP_DA2_DONE:   da_q <= qt_q;
			OP_DB_INIT:    begin dv_q <= nb_q; dr_q <= gy_q; rm_q <= '0; qt_q <= '0; end
			OP_DB_DONE:    nb_q <= qt_q;
			OP_DB2_INIT:   begin dv_q <= db_q; dr_q <= gy_q; rm_q <= '0; qt_q <= '0; end
			OP_DB2_DONE:   db_q <= qt_q;
			OP_MUL1: p1_q <= mul_p;
			OP_MUL2: p2_q <= mul_p;
			OP_MUL3: p3_q <= mul_p;
			OP_COMB: begin
				case (op_q)
					CMD_ADD, CMD_SUB: begin
						d_q <= p3_q;
						if (sa_q == s2) begin
							n_q <= p1_q + p2_q; sign_q <= sa_q;
						end else if (p1_q >= p2_q) begin
							n_q <= p1_q - p2_q; sign_q <= sa_q;
						end else begin
							n_q <= p2_q - p1_q; sign_q <= s2;
						end
					end
					CMD_MUL: begin
						n_q <= p1_q; d_q <= p3_q; sign_q <= sa_q ^ sb_q;
					end
					CMD_DIV: begin
						if (nb_q == '0) begin
							inf_q <= 1'b1; n_q <= '0; d_q <= WW'(1); sign_q <= 1'b0;
						end else begin
							n_q <= p1_q; d_q <= p2_q; sign_q <= sa_q ^ sb_q;
						end
					end
					default: begin n_q <= na_q; d_q <= da_q; sign_q <= sa_q; end
				endcase
			end
			OP_SPLIT_INIT: begin
				whole_q <= '0; fn_q <= '0; fd_q <= WW'(1);
				if (n_q == '0) sign_q <= 1'b0;
				dv_q <= n_q; dr_q <= d_q; rm_q <= '0; qt_q <= '0;
			end
			OP_SPLIT_DONE: begin whole_q <= qt_q; fn_q <= rm_q; end
			OP_DF_INIT:    begin dv_q <= fn_q; dr_q <= gy_q; rm_q <= '0; qt_q <= '0; end
			OP_DF_DONE:    fn_q <= qt_q;
			OP_DF2_INIT:   begin dv_q <= d_q; dr_q <= gy_q; rm_q <= '0; qt_q <= '0; end
			OP_DF2_DONE:   fd_q <= qt_q;
			default: ;
		endcase
	end

	always_comb begin
		stat.gcd_done = (cnt_q == '0) && (rm_q == '0);
		stat.div_done = (cnt_q == '0);
		stat.na_zero  = (na_q == '0);
		stat.nb_zero  = (nb_q == '0);
		stat.n_zero   = (n_q == '0);
		stat.fn_zero  = (fn_q == '0);
	end

	always_comb begin
		out_data.negative   = sign_q;
		out_data.whole_part = whole_q[62:0];
		out_data.frac_num   = fn_q[61:0];
		out_data.frac_den   = fd_q[62:0];
		out_data.infinite   = inf_q;
	end

endmodule

FILE: rtl/rational_arithmetic_unit_core.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_core: rational add/sub/mul/div/reduce
// Operand reduction, exact combine, mixed-number split and reduction.
// ----------------------------------------------------------------------------
// One item at a time. Latency is data dependent: each gcd runs one
// divider pass of 64 restoring steps per Euclid remainder, then moves the
// pair up; each exact division is one divider pass, and the products and
// combine follow the operand reductions. Zero operands skip their stages.
// The result holds in_ready low until taken.
module rational_arithmetic_unit_core import rau_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  rau_in_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output rau_out_t out_data
);

	rau_cmd_t  cmd;
	rau_stat_t stat;

	rau_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready,
		.stat, .cmd
	);

	rau_dp u_dp (
		.clk, .arst_n, .in_data, .cmd, .stat, .out_data
	);

endmodule

FILE: rtl/rau_checker.sv
// ----------------------------------------------------------------------------
// rau_checker: port-level checks for the core
// Handshake stability and result flag consistency.
// ----------------------------------------------------------------------------
module rau_checker import rau_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     in_valid,
	input logic     in_ready,
	input logic     out_valid,
	input logic     out_ready,
	input rau_out_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input taken while result pending");

	a_inf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.infinite |-> out_data.whole_part == '0 &&
		out_data.frac_num == '0 && !out_data.negative)
		else $error("infinite result not zero");

	a_den_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.frac_num == '0 |-> out_data.frac_den == 63'd1)
		else $error("integral result with denominator other than one");

endmodule

bind rational_arithmetic_unit_core rau_checker u_rau_checker (
	.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_data
);
